>>> sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants shared by the postfix stack evaluator modules.
// ----------------------------------------------------------------------------
package pse_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expression;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } out_item_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Datapath operation codes.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_POW   = 3'd5
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic digit;     // fold a digit into the accumulator
        logic clr_num;   // clear the accumulator
        logic push_acc;  // push accumulator (write RAM)
        logic rd_b;      // read top entry
        logic rd_a;      // read second entry, latch b
        logic lat_a;     // latch a
        logic start;     // start the selected operation
        logic push_res;  // push the operation result
        logic rd_bot;    // read stack bottom
        logic clr_stk;   // clear stack count
        op_t  op;
    } cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic full;
        logic lt2;
        logic cnt1;
        logic b_zero;
        logic busy;
    } sts_t;

endpackage

>>> sv/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Stack memory, number accumulator and the shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
module pse_datapath #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pse_pkg::cmd_t       cmd,
    input  logic [3:0]          digit_val,
    output pse_pkg::sts_t       sts,
    output logic [31:0]         bottom
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   a_reg, b_reg, res_reg;
    logic [31:0]   rdata;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    // Iterative unit state.
    logic [5:0]    it_reg;
    logic          busy_reg;
    logic [31:0]   rem_reg, quo_reg, dvs_reg, base_reg, exp_reg;
    logic          neg_q_reg;
    logic [32:0]   trial;

    assign we    = cmd.push_acc || cmd.push_res;
    assign waddr = cnt_reg[AW-1:0];
    assign wdata = cmd.push_res ? res_reg : acc_reg;

    // Read address: top, second or bottom entry.
    always_comb
    begin
        if (cmd.rd_bot)
        begin
            raddr = '0;
        end
        else if (cmd.rd_b)
        begin
            raddr = AW'(cnt_reg - CW'(1));
        end
        else
        begin
            raddr = AW'(cnt_reg - CW'(2));
        end
    end

    pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign bottom = rdata;

    // Stack count and accumulator.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clr_stk)
        begin
            cnt_next = '0;
        end
        else if (we)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.lat_a)
        begin
            cnt_next = cnt_reg - CW'(2);
        end
        acc_next = acc_reg;
        if (cmd.clr_num)
        begin
            acc_next = '0;
        end
        else if (cmd.digit)
        begin
            acc_next = (acc_reg << 3) + (acc_reg << 1) + {28'd0, digit_val};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            acc_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            if (cmd.start && (cmd.op == pse_pkg::OP_DIV || cmd.op == pse_pkg::OP_POW))
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && it_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    // Operand latches and the shared iterative unit.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_a)
        begin
            b_reg <= rdata;
        end
        if (cmd.lat_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.start)
        begin
            case (cmd.op)
                pse_pkg::OP_ADD: res_reg <= a_reg + b_reg;
                pse_pkg::OP_SUB: res_reg <= a_reg - b_reg;
                pse_pkg::OP_MUL: res_reg <= a_reg * b_reg;
                pse_pkg::OP_DIV:
                begin
                    rem_reg   <= '0;
                    quo_reg   <= a_reg[31] ? -a_reg : a_reg;
                    dvs_reg   <= b_reg[31] ? -b_reg : b_reg;
                    neg_q_reg <= a_reg[31] ^ b_reg[31];
                    it_reg    <= 6'd32;
                end
                pse_pkg::OP_POW:
                begin
                    res_reg  <= 32'd1;
                    base_reg <= a_reg;
                    exp_reg  <= b_reg[31] ? 32'd0 : b_reg;
                    it_reg   <= 6'd31;
                end
                default: res_reg <= res_reg;
            endcase
        end
        else if (busy_reg)
        begin
            if (cmd.op == pse_pkg::OP_DIV)
            begin
                if (it_reg == 6'd0)
                begin
                    res_reg <= neg_q_reg ? -quo_reg : quo_reg;
                end
                else
                begin
                    // One restoring division step.
                    if (!trial[32])
                    begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg - 6'd1;
                end
            end
            else if (it_reg != 6'd0)
            begin
                // One square-and-multiply step; square and multiply both
                // come from registers.
                if (exp_reg[0])
                begin
                    res_reg <= res_reg * base_reg;
                end
                base_reg <= base_reg * base_reg;
                exp_reg  <= exp_reg >> 1;
                it_reg   <= it_reg - 6'd1;
            end
        end
    end

    assign sts.full   = (cnt_reg >= CW'(STACK_DEPTH));
    assign sts.lt2    = (cnt_reg < CW'(2));
    assign sts.cnt1   = (cnt_reg == CW'(1));
    assign sts.b_zero = (b_reg == 32'd0);
    assign sts.busy   = busy_reg;
endmodule

>>> sv/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Controller: decodes each character and sequences the datapath.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pse_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pse_pkg::out_item_t  out_data,
    output pse_pkg::cmd_t       cmd,
    output logic [3:0]          digit_val,
    input  pse_pkg::sts_t       sts,
    input  logic [31:0]         bottom
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PUSHN = 11'b00000000010,
        S_RDB   = 11'b00000000100,
        S_RDA   = 11'b00000001000,
        S_LATA  = 11'b00000010000,
        S_EXEC  = 11'b00000100000,
        S_WAIT  = 11'b00001000000,
        S_PUSHR = 11'b00010000000,
        S_ENDP  = 11'b00100000000,
        S_ENDR  = 11'b01000000000,
        S_ENDO  = 11'b10000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [7:0]     ch_reg, ch_next;
    logic           end_reg, end_next;
    logic           pend_reg, pend_next;
    logic [1:0]     err_reg, err_next;
    pse_pkg::op_t   op_reg, op_next;
    logic           ov_reg, ov_next;
    pse_pkg::out_item_t od_reg, od_next;

    logic accept, is_digit, is_op;
    pse_pkg::op_t dec_op;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign digit_val = 4'(in_data.char_code - pse_pkg::CH_ZERO);
    assign is_digit  = (in_data.char_code >= pse_pkg::CH_ZERO) &&
                       (in_data.char_code <= pse_pkg::CH_NINE);

    // Operator decode.
    always_comb
    begin
        case (ch_reg)
            pse_pkg::CH_PLUS:  dec_op = pse_pkg::OP_ADD;
            pse_pkg::CH_MINUS: dec_op = pse_pkg::OP_SUB;
            pse_pkg::CH_MUL:   dec_op = pse_pkg::OP_MUL;
            pse_pkg::CH_DIV:   dec_op = pse_pkg::OP_DIV;
            pse_pkg::CH_POW:   dec_op = pse_pkg::OP_POW;
            pse_pkg::CH_SPACE: dec_op = pse_pkg::OP_NONE;
            default:           dec_op = pse_pkg::OP_NONE;
        endcase
    end
    assign is_op = (dec_op != pse_pkg::OP_NONE);

    // Next-state and command logic.
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        end_next   = end_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        op_next    = op_reg;
        ov_next    = ov_reg && out_stall;
        od_next    = od_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next  = in_data.char_code;
                    end_next = in_data.end_of_expression;
                    if (is_digit)
                    begin
                        if (err_reg == pse_pkg::ST_OK)
                        begin
                            cmd.digit = 1'b1;
                            pend_next = 1'b1;
                        end
                        state_next = in_data.end_of_expression ? S_ENDP : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PUSHN;
                    end
                end
            end
            S_PUSHN:
            begin
                // Push the pending number, then dispatch the character.
                if (pend_reg && err_reg == pse_pkg::ST_OK)
                begin
                    if (sts.full)
                    begin
                        err_next = pse_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push_acc = 1'b1;
                    end
                end
                pend_next   = 1'b0;
                cmd.clr_num = 1'b1;
                op_next     = dec_op;
                state_next  = end_reg ? S_ENDP : S_IDLE;
                if (is_op && !(pend_reg && sts.full) && err_reg == pse_pkg::ST_OK)
                begin
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                if (sts.lt2)
                begin
                    err_next   = pse_pkg::ST_INVALID;
                    state_next = end_reg ? S_ENDP : S_IDLE;
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_LATA;
            end
            S_LATA:
            begin
                cmd.lat_a  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (op_reg == pse_pkg::OP_DIV && sts.b_zero)
                begin
                    err_next   = pse_pkg::ST_DIVZERO;
                    state_next = end_reg ? S_ENDP : S_IDLE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = (op_reg == pse_pkg::OP_DIV || op_reg == pse_pkg::OP_POW)
                                 ? S_WAIT : S_PUSHR;
                end
            end
            S_WAIT:
            begin
                if (!sts.busy)
                begin
                    state_next = S_PUSHR;
                end
            end
            S_PUSHR:
            begin
                // Two entries were popped, so the push always fits.
                cmd.push_res = 1'b1;
                state_next   = end_reg ? S_ENDP : S_IDLE;
            end
            S_ENDP:
            begin
                // Final push of a trailing number.
                if (pend_reg && err_reg == pse_pkg::ST_OK)
                begin
                    if (sts.full)
                    begin
                        err_next = pse_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push_acc = 1'b1;
                    end
                end
                pend_next   = 1'b0;
                cmd.clr_num = 1'b1;
                state_next  = S_ENDR;
            end
            S_ENDR:
            begin
                // Read the stack bottom; its data arrives in the next state.
                cmd.rd_bot = 1'b1;
                state_next = S_ENDO;
            end
            S_ENDO:
            begin
                cmd.rd_bot = 1'b1;
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    if (err_reg == pse_pkg::ST_OK && !sts.cnt1)
                    begin
                        od_next.status = pse_pkg::ST_INVALID;
                    end
                    else
                    begin
                        od_next.status = err_reg;
                    end
                    od_next.value = (od_next.status == pse_pkg::ST_OK) ? bottom : '0;
                    cmd.clr_stk   = 1'b1;
                    err_next      = pse_pkg::ST_OK;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            err_reg   <= pse_pkg::ST_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        end_reg <= end_next;
        op_reg  <= op_next;
        od_reg  <= od_next;
    end
endmodule

>>> sv/postfix_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix integer expression evaluator, one character per input item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one character per
//   item with an end-of-expression flag. The output channel (out_valid,
//   out_stall, out_data) gives one item, value and status, per expression.
//   A digit is folded into the number as it is taken. Any other character
//   first pushes the pending number; an operator then reads and latches its
//   operands, executes and pushes the result, and divide and power wait on
//   the shared iterative unit that does one bit a cycle.
//   The end of an expression adds a final push, a stack bottom read and a
//   result load; the result is shown the cycle after the load.
//   The result waits in an output register while out_stall is high; input
//   items are still accepted meanwhile, and the next result waits until
//   the register is free.
//   Reset clears the stack count, number, error and output valid; the stack
//   memory itself is not cleared.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pse_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pse_pkg::out_item_t  out_data
);
    pse_pkg::cmd_t cmd;
    pse_pkg::sts_t sts;
    logic [3:0]    digit_val;
    logic [31:0]   bottom;

    pse_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cmd(cmd), .digit_val(digit_val), .sts(sts), .bottom(bottom)
    );

    pse_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .digit_val(digit_val),
        .sts(sts), .bottom(bottom)
    );
endmodule

>>> sv/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator.
// ----------------------------------------------------------------------------
module pse_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input pse_pkg::in_item_t   in_data,
    input logic                out_valid,
    input logic                out_stall,
    input pse_pkg::out_item_t  out_data
);
    // A held result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A failing status always carries a zero value.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != pse_pkg::ST_OK |-> out_data.value == 0)
        else $error("nonzero value with error");

    // An accepted end item is never followed by acceptance the next cycle.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.end_of_expression |=> in_stall)
        else $error("accept right after end");

    // The handshake outputs are always known.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("unknown handshake output");
endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (.*);
